// ===== rtl/spa_pkg.sv =====
// Shared constants and control types of the surface pool allocator.
package spa_pkg;

  localparam int POOL_SLOTS = 32;
  localparam int STAMP_W    = 32;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int CFG_W      = 6;
  localparam int GRANT_W    = 5;
  localparam int IDX_W      = 5;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef struct packed {
    logic load_item;  // capture the request and restart the scan
    logic scan_step;  // slot under the scan is busy: read its stamp, advance
    logic take_free;  // slot under the scan is free: grant it
    logic commit;     // update the pool and load the result register
  } spa_cmd_t;

  typedef struct packed {
    logic is_release; // captured request is a release
    logic cur_free;   // slot under the scan is free
    logic at_last;    // scan sits on the last searched slot
    logic out_free;   // result register can take a new result
  } spa_stat_t;

endpackage

// ===== rtl/spa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module spa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/spa_dp.sv =====
// Datapath: busy marks, stamp memory, scan counter, oldest tracker and result register.
module spa_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spa_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_action_i,
  input  logic [spa_pkg::IDX_W-1:0]    in_slot_index_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [spa_pkg::GRANT_W-1:0]  out_granted_slot_o,
  output logic                         out_took_busy_o,
  output logic                         out_was_release_o,
  input  spa_pkg::spa_cmd_t            cmd_i,
  output spa_pkg::spa_stat_t           stat_o
);

  logic [spa_pkg::CFG_W-1:0]      cfg_q;
  logic [spa_pkg::POOL_SLOTS-1:0] busy_q;
  logic [spa_pkg::STAMP_W-1:0]    counter_q;
  logic                           action_q;
  logic [spa_pkg::IDX_W-1:0]      rel_idx_q;
  logic [spa_pkg::SLOT_W-1:0]     k_q;
  logic [spa_pkg::SLOT_W-1:0]     pick_q;
  logic                           use_oldest_q;
  logic                           pend_q;
  logic [spa_pkg::SLOT_W-1:0]     pend_idx_q;
  logic [spa_pkg::STAMP_W-1:0]    oldest_stamp_q;
  logic [spa_pkg::SLOT_W-1:0]     oldest_idx_q;
  logic                           out_valid_q;
  logic [spa_pkg::GRANT_W-1:0]    out_slot_q;
  logic                           out_busy_q;
  logic                           out_rel_q;

  logic [spa_pkg::SLOT_W-1:0]     last_idx;
  logic [spa_pkg::SLOT_W-1:0]     grant;
  logic [spa_pkg::STAMP_W-1:0]    rdata;
  logic                           rel_in_range;
  logic                           acq_commit;

  // Last searched slot: a count of zero acts as one, a count above the pool as the pool.
  always_comb begin
    if (cfg_q == '0) begin
      last_idx = '0;
    end else if (int'(cfg_q) > spa_pkg::POOL_SLOTS) begin
      last_idx = spa_pkg::SLOT_W'(spa_pkg::POOL_SLOTS - 1);
    end else begin
      last_idx = spa_pkg::SLOT_W'(cfg_q - spa_pkg::CFG_W'(1));
    end
  end

  assign grant        = use_oldest_q ? oldest_idx_q : pick_q;
  assign rel_in_range = int'(rel_idx_q) < spa_pkg::POOL_SLOTS;
  assign acq_commit   = cmd_i.commit && (action_q == spa_pkg::ACT_ACQUIRE);

  // Stamps are only read for busy slots, and a slot turns busy only when its stamp is
  // written, so the memory needs no clearing after reset.
  spa_ram #(
    .WIDTH (spa_pkg::STAMP_W),
    .DEPTH (spa_pkg::POOL_SLOTS)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (acq_commit),
    .waddr_i (grant),
    .wdata_i (counter_q),
    .raddr_i (k_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= spa_pkg::CFG_RESET;
      busy_q      <= '0;
      counter_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      pend_q <= cmd_i.scan_step;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (action_q == spa_pkg::ACT_RELEASE) begin
          if (rel_in_range) begin
            busy_q[spa_pkg::SLOT_W'(rel_idx_q)] <= 1'b0;
          end
        end else begin
          busy_q[grant] <= 1'b1;
          counter_q     <= counter_q + spa_pkg::STAMP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q     <= in_action_i;
      rel_idx_q    <= in_slot_index_i;
      k_q          <= '0;
      use_oldest_q <= 1'b1;
    end
    if (cmd_i.scan_step) begin
      pend_idx_q <= k_q;
      k_q        <= k_q + spa_pkg::SLOT_W'(1);
    end
    if (cmd_i.take_free) begin
      pick_q       <= k_q;
      use_oldest_q <= 1'b0;
    end
    // The first stamp of a scan seeds the tracker; a tie keeps the lower slot.
    if (pend_q && ((pend_idx_q == '0) || (rdata < oldest_stamp_q))) begin
      oldest_stamp_q <= rdata;
      oldest_idx_q   <= pend_idx_q;
    end
    if (cmd_i.commit) begin
      if (action_q == spa_pkg::ACT_RELEASE) begin
        out_slot_q <= '0;
        out_busy_q <= 1'b0;
        out_rel_q  <= 1'b1;
      end else begin
        out_slot_q <= spa_pkg::GRANT_W'(grant);
        out_busy_q <= use_oldest_q;
        out_rel_q  <= 1'b0;
      end
    end
  end

  assign stat_o.is_release = (action_q == spa_pkg::ACT_RELEASE);
  assign stat_o.cur_free   = !busy_q[k_q];
  assign stat_o.at_last    = (k_q == last_idx);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign out_granted_slot_o = out_slot_q;
  assign out_took_busy_o    = out_busy_q;
  assign out_was_release_o  = out_rel_q;

endmodule

// ===== rtl/spa_ctrl.sv =====
// Controller: sequences request capture, slot scan, drain and commit.
module spa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spa_pkg::spa_stat_t stat_i,
  output spa_pkg::spa_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.is_release) begin
          state_d = ST_COMMIT;
        end else if (stat_i.cur_free) begin
          cmd_o.take_free = 1'b1;
          state_d         = ST_COMMIT;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (stat_i.at_last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ===== rtl/surface_pool_allocator_unit.sv =====
// Top level of the surface pool allocator: controller, datapath and stream ports.
//
// The slave stream carries one request per transfer: tuser is the action (0 acquire,
// 1 release) and tdata holds the slot to release. The master stream returns exactly
// one result per request: the granted slot and a flag that no slot was free and the
// oldest busy slot was reused, with tuser set when the result acknowledges a release.
// The one configuration register sets how many slots an acquire searches; write it
// only while no request is in flight.
// An acquire scans the slots one per cycle, reading each busy slot's issue stamp
// from the stamp memory; it ends at the first free slot, or, when every searched
// slot is busy, passes a drain state for the last stamp read before its commit.
// A release goes from the scan state straight to its commit.
// The next request can be accepted at the earliest at the edge where the result can
// first be taken, so requests are handled one at a time.
// Reset frees every slot, clears the issue counter and sets the count to 32; the
// block is ready as soon as reset ends. A stalled receiver holds the result
// in the output register; the next request may already be accepted and is finished
// up to its commit, where it waits until the result register is free.
module surface_pool_allocator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spa_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [4:0] slot_index, [7:5] zero
  input  logic [spa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] action
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [4:0] granted_slot, [5] took_busy, [7:6] zero
  output logic [spa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] was_release
  output logic                              m_axis_tuser
);

  spa_pkg::spa_cmd_t  cmd;
  spa_pkg::spa_stat_t stat;

  logic [spa_pkg::GRANT_W-1:0] granted_slot;
  logic                        took_busy;

  spa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spa_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_action_i        (s_axis_tuser),
    .in_slot_index_i    (s_axis_tdata[spa_pkg::IDX_W-1:0]),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .out_granted_slot_o (granted_slot),
    .out_took_busy_o    (took_busy),
    .out_was_release_o  (m_axis_tuser),
    .cmd_i              (cmd),
    .stat_o             (stat)
  );

  assign m_axis_tdata = {2'b00, took_busy, granted_slot};

endmodule
